FILE: rtl/ratiometric_impedance_calc_top_macros.svh
// Assertion macros shared by the ratiometric impedance calculator RTL.
`ifndef RATIOMETRIC_IMPEDANCE_CALC_TOP_MACROS_SVH
`define RATIOMETRIC_IMPEDANCE_CALC_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ric assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ric assertion failed");

`endif

FILE: rtl/ric_pkg.sv
// Shared widths, constants and the arctangent table of the impedance calculator.
package ric_pkg;

	localparam int IN_W        = 32;
	localparam int R_W         = 17;
	localparam int MAG_W       = 56;
	localparam int PH_W        = 18;
	localparam int PART_W      = 57;
	localparam int SQ_W        = 64;
	localparam int RSQ_W       = 34;
	localparam int MAG_NUM_W   = 114;
	localparam int MAG_QUO_W   = 112;
	localparam int PART_NUM_W  = 89;
	localparam int PART_QUO_W  = 56;
	localparam int SQRT_RW     = 60;
	localparam int ANG_W       = 28;
	localparam int CORDIC_W    = 36;
	localparam int CORDIC_STEPS = 20;
	localparam int PHASE_LIM   = 92160;

	localparam logic [R_W-1:0] R_RESET = 17'd200;
	localparam logic signed [ANG_W-1:0] ANG_180 = 28'sd11796480;
	localparam logic signed [ANG_W-1:0] ANG_90  = 28'sd5898240;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
		logic signed [ANG_W-1:0] v;
		case (i)
			0:  v = 28'sd2949120;
			1:  v = 28'sd1740967;
			2:  v = 28'sd919879;
			3:  v = 28'sd466945;
			4:  v = 28'sd234379;
			5:  v = 28'sd117304;
			6:  v = 28'sd58666;
			7:  v = 28'sd29335;
			8:  v = 28'sd14668;
			9:  v = 28'sd7334;
			10: v = 28'sd3667;
			11: v = 28'sd1833;
			12: v = 28'sd917;
			13: v = 28'sd458;
			14: v = 28'sd229;
			15: v = 28'sd115;
			16: v = 28'sd57;
			17: v = 28'sd29;
			18: v = 28'sd14;
			19: v = 28'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/ric_if.sv
// Valid/ready channel interfaces for input items and result items.
interface ric_item_if;
	logic valid;
	logic ready;
	logic signed [ric_pkg::IN_W-1:0] ref_real;
	logic signed [ric_pkg::IN_W-1:0] ref_imag;
	logic signed [ric_pkg::IN_W-1:0] cell_real;
	logic signed [ric_pkg::IN_W-1:0] cell_imag;
	modport source (output valid, ref_real, ref_imag, cell_real, cell_imag, input ready);
	modport sink (input valid, ref_real, ref_imag, cell_real, cell_imag, output ready);
endinterface

interface ric_result_if;
	logic valid;
	logic ready;
	logic [ric_pkg::MAG_W-1:0] z_magnitude;
	logic signed [ric_pkg::PH_W-1:0] z_phase;
	logic signed [ric_pkg::PART_W-1:0] z_real;
	logic signed [ric_pkg::PART_W-1:0] z_imag;
	modport source (output valid, z_magnitude, z_phase, z_real, z_imag, input ready);
	modport sink (input valid, z_magnitude, z_phase, z_real, z_imag, output ready);
endinterface

FILE: rtl/ric_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ric_div #(
	parameter int NUM_W = ric_pkg::MAG_NUM_W,
	parameter int QUO_W = ric_pkg::MAG_QUO_W,
	parameter int DEN_W = ric_pkg::SQ_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] n,
	input  logic [DEN_W-1:0] d,
	output logic [QUO_W-1:0] q,
	output logic             sat
);

	logic [DEN_W-1:0] rem_s [QUO_W+1];
	logic [QUO_W-1:0] nq_s  [QUO_W+1];
	logic [DEN_W-1:0] d_s   [QUO_W+1];
	logic             sat_s [QUO_W+1];
	logic [DEN_W-1:0] n_hi;

	assign n_hi = DEN_W'(n[NUM_W-1:QUO_W]);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= n_hi;
			nq_s[0]  <= n[QUO_W-1:0];
			d_s[0]   <= d;
			sat_s[0] <= n_hi >= d;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] t;
		logic [DEN_W:0] diff;
		logic           ge;
		assign t    = {rem_s[k], nq_s[k][QUO_W-1]};
		assign diff = t - {1'b0, d_s[k]};
		assign ge   = t >= {1'b0, d_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
				nq_s[k+1]  <= {nq_s[k][QUO_W-2:0], ge};
				d_s[k+1]   <= d_s[k];
				sat_s[k+1] <= sat_s[k];
			end
		end
	end

	assign q   = nq_s[QUO_W];
	assign sat = sat_s[QUO_W];

endmodule

FILE: rtl/ric_cordic.sv
// Pipelined vectoring CORDIC that returns the angle of a vector in 2^-16 degree.
module ric_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ric_pkg::IN_W-1:0]     x,
	input  logic signed [ric_pkg::IN_W-1:0]     y,
	output logic signed [ric_pkg::ANG_W-1:0]    z
);

	localparam int W = ric_pkg::CORDIC_W;
	localparam int STEPS = ric_pkg::CORDIC_STEPS;

	logic signed [W-1:0]              x_s [STEPS+1];
	logic signed [W-1:0]              y_s [STEPS+1];
	logic signed [ric_pkg::ANG_W-1:0] z_s [STEPS+1];
	logic                             fixed_s [STEPS+1];

	logic signed [W-1:0]              x0, y0, xe, ye;
	logic signed [ric_pkg::ANG_W-1:0] z0;
	logic                             f0;

	assign xe = W'(x);
	assign ye = W'(y);

	// Axis vectors get their exact angle and skip the iterations.
	always_comb begin
		x0 = xe;
		y0 = ye;
		z0 = '0;
		f0 = 1'b0;
		if (y == 0) begin
			f0 = 1'b1;
			z0 = (x < 0) ? ric_pkg::ANG_180 : '0;
		end else if (x == 0) begin
			f0 = 1'b1;
			z0 = (y > 0) ? ric_pkg::ANG_90 : -ric_pkg::ANG_90;
		end else if (x < 0) begin
			z0 = (y > 0) ? ric_pkg::ANG_180 : -ric_pkg::ANG_180;
			x0 = -xe;
			y0 = -ye;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]     <= x0;
			y_s[0]     <= y0;
			z_s[0]     <= z0;
			fixed_s[0] <= f0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic signed [W-1:0] dx, dy;
		logic                ypos;
		assign dx   = y_s[k] >>> k;
		assign dy   = x_s[k] >>> k;
		assign ypos = y_s[k] > 0;
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]     <= ypos ? x_s[k] + dx : x_s[k] - dx;
				y_s[k+1]     <= ypos ? y_s[k] - dy : y_s[k] + dy;
				fixed_s[k+1] <= fixed_s[k];
				if (fixed_s[k]) begin
					z_s[k+1] <= z_s[k];
				end else if (ypos) begin
					z_s[k+1] <= z_s[k] + ric_pkg::atan_entry(k);
				end else begin
					z_s[k+1] <= z_s[k] - ric_pkg::atan_entry(k);
				end
			end
		end
	end

	assign z = z_s[STEPS];

endmodule

FILE: rtl/ratiometric_impedance_calc_top.sv
// Top level of the ratiometric impedance calculator pipeline.
// One item per cycle is accepted while the output register is empty or its result is taken.
// The longest path runs through the 112-stage magnitude divider followed by the 56-stage square root.
// When a finished result is not taken, the whole pipeline holds and input ready drops.
// Reset clears all valid bits and sets reference_ohms to 200 ohms.
`include "ratiometric_impedance_calc_top_macros.svh"

module ratiometric_impedance_calc_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ric_pkg::R_W-1:0]    cfg_wdata,
	ric_item_if.sink                   item,
	ric_result_if.source               result
);

	localparam int IN_W   = ric_pkg::IN_W;
	localparam int SQ_W   = ric_pkg::SQ_W;
	localparam int MAG_W  = ric_pkg::MAG_W;
	localparam int PART_W = ric_pkg::PART_W;
	localparam int PH_W   = ric_pkg::PH_W;
	localparam int ANG_W  = ric_pkg::ANG_W;
	localparam int RW     = ric_pkg::SQRT_RW;
	localparam int MQW    = ric_pkg::MAG_QUO_W;
	localparam int PQW    = ric_pkg::PART_QUO_W;

	localparam int DIV_IN       = 4;
	localparam int MAG_DIV_OUT  = DIV_IN + MQW + 1;
	localparam int LAST         = MAG_DIV_OUT + MAG_W;
	localparam int PART_DIV_OUT = DIV_IN + PQW + 1;
	localparam int PH_ST        = ric_pkg::CORDIC_STEPS + 2;
	localparam int PH_DLY       = LAST - PH_ST;
	localparam int PART_DLY     = LAST - (PART_DIV_OUT + 1);
	localparam int NEG_DLY      = PART_DIV_OUT - 2;

	localparam logic signed [PART_W-1:0] POS_SAT = {1'b0, {(PART_W-1){1'b1}}};
	localparam logic signed [PART_W-1:0] NEG_SAT = {1'b1, {(PART_W-1){1'b0}}};

	logic                      adv;
	logic [ric_pkg::R_W-1:0]   reference_ohms_q;
	logic [LAST-1:0]           v_s;

	assign adv = !result.valid || result.ready;
	assign item.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_ohms_q <= ric_pkg::R_RESET;
		end else if (cfg_we) begin
			reference_ohms_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s          <= '0;
			result.valid <= 1'b0;
		end else if (adv) begin
			v_s          <= {v_s[LAST-2:0], item.valid};
			result.valid <= v_s[LAST-1];
		end
	end

	// Stage 1: all cross products.
	logic signed [2*IN_W-1:0]  p_rr_s1, p_ii_s1, p_cr_s1, p_ci_s1;
	logic signed [2*IN_W-1:0]  p_a_s1, p_b_s1, p_c_s1, p_d_s1;
	logic signed [IN_W-1:0]    rr_s1, ri_s1;
	logic [ric_pkg::RSQ_W-1:0] rsq_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_rr_s1 <= item.ref_real * item.ref_real;
			p_ii_s1 <= item.ref_imag * item.ref_imag;
			p_cr_s1 <= item.cell_real * item.cell_real;
			p_ci_s1 <= item.cell_imag * item.cell_imag;
			p_a_s1  <= item.ref_real * item.cell_real;
			p_b_s1  <= item.ref_imag * item.cell_imag;
			p_c_s1  <= item.ref_real * item.cell_imag;
			p_d_s1  <= item.ref_imag * item.cell_real;
			rr_s1   <= item.ref_real;
			ri_s1   <= item.ref_imag;
			rsq_s1  <= reference_ohms_q * reference_ohms_q;
		end
	end

	// Stage 2: energies and the signed real and imaginary numerators.
	logic [SQ_W-1:0]           sr_s2, sc_s2, pm_s2, qm_s2;
	logic                      pn_s2, qn_s2;
	logic [ric_pkg::RSQ_W-1:0] rsq_s2;
	logic [SQ_W-1:0]           sc_raw, pm_c, qm_c;
	logic signed [SQ_W:0]      sp, sq;
	logic signed [IN_W:0]      rre, rie, rra, ria;
	logic                      zc, pn_c, qn_c;

	always_comb begin
		sc_raw = $unsigned(p_cr_s1) + $unsigned(p_ci_s1);
		zc     = sc_raw == '0;
		sp     = (SQ_W+1)'(p_a_s1) + (SQ_W+1)'(p_b_s1);
		sq     = (SQ_W+1)'(p_c_s1) - (SQ_W+1)'(p_d_s1);
		rre    = (IN_W+1)'(rr_s1);
		rie    = (IN_W+1)'(ri_s1);
		rra    = (rre < 0) ? -rre : rre;
		ria    = (rie < 0) ? -rie : rie;
		if (zc) begin
			pn_c = rr_s1 < 0;
			pm_c = SQ_W'($unsigned(rra));
			qn_c = ri_s1 > 0;
			qm_c = SQ_W'($unsigned(ria));
		end else begin
			pn_c = sp < 0;
			pm_c = (sp < 0) ? SQ_W'(-sp) : SQ_W'(sp);
			qn_c = sq < 0;
			qm_c = (sq < 0) ? SQ_W'(-sq) : SQ_W'(sq);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sr_s2  <= $unsigned(p_rr_s1) + $unsigned(p_ii_s1);
			sc_s2  <= zc ? SQ_W'(1) : sc_raw;
			pm_s2  <= pm_c;
			qm_s2  <= qm_c;
			pn_s2  <= pn_c;
			qn_s2  <= qn_c;
			rsq_s2 <= rsq_s1;
		end
	end

	// Stage 3: partial products of the scaled numerators.
	logic [SQ_W/2+ric_pkg::RSQ_W-1:0]   mpl_s3, mph_s3;
	logic [SQ_W/2+ric_pkg::R_W-1:0]     ppl_s3, pph_s3, qpl_s3, qph_s3;
	logic [SQ_W-1:0]                    sc_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			mpl_s3 <= sr_s2[SQ_W/2-1:0] * rsq_s2;
			mph_s3 <= sr_s2[SQ_W-1:SQ_W/2] * rsq_s2;
			ppl_s3 <= pm_s2[SQ_W/2-1:0] * reference_ohms_q;
			pph_s3 <= pm_s2[SQ_W-1:SQ_W/2] * reference_ohms_q;
			qpl_s3 <= qm_s2[SQ_W/2-1:0] * reference_ohms_q;
			qph_s3 <= qm_s2[SQ_W-1:SQ_W/2] * reference_ohms_q;
			sc_s3  <= sc_s2;
		end
	end

	// Stage 4: full numerators.
	localparam int NM_W = SQ_W + ric_pkg::RSQ_W;
	localparam int NP_W = SQ_W + ric_pkg::R_W;
	logic [NM_W-1:0] nm_s4;
	logic [NP_W-1:0] np_s4, nq_s4;
	logic [SQ_W-1:0] sc_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s4 <= {mph_s3, {(SQ_W/2){1'b0}}} + NM_W'(mpl_s3);
			np_s4 <= {pph_s3, {(SQ_W/2){1'b0}}} + NP_W'(ppl_s3);
			nq_s4 <= {qph_s3, {(SQ_W/2){1'b0}}} + NP_W'(qpl_s3);
			sc_s4 <= sc_s3;
		end
	end

	logic [MQW-1:0] qmag;
	logic           smag;
	logic [PQW-1:0] qre, qim;
	logic           sre, sim;

	ric_div #(.NUM_W(ric_pkg::MAG_NUM_W), .QUO_W(MQW), .DEN_W(SQ_W)) u_div_mag (
		.clk (clk), .en (adv), .n ({nm_s4, 16'b0}), .d (sc_s4), .q (qmag), .sat (smag)
	);

	ric_div #(.NUM_W(ric_pkg::PART_NUM_W), .QUO_W(PQW), .DEN_W(SQ_W)) u_div_re (
		.clk (clk), .en (adv), .n ({np_s4, 8'b0}), .d (sc_s4), .q (qre), .sat (sre)
	);

	ric_div #(.NUM_W(ric_pkg::PART_NUM_W), .QUO_W(PQW), .DEN_W(SQ_W)) u_div_im (
		.clk (clk), .en (adv), .n ({nq_s4, 8'b0}), .d (sc_s4), .q (qim), .sat (sim)
	);

	// Square root of the magnitude quotient, one root bit per stage.
	logic [RW-1:0]    sq_rem_s  [MAG_W];
	logic [MAG_W-1:0] sq_root_s [MAG_W];
	logic [MQW-1:0]   sq_q_s    [MAG_W];
	logic             sq_sat_s  [MAG_W];

	for (genvar k = 0; k < MAG_W; k++) begin : g_sqrt
		logic [RW-1:0]    rem_in, t, trial;
		logic [MAG_W-1:0] root_in;
		logic [MQW-1:0]   q_in;
		logic             sat_in, ge;
		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign q_in    = qmag;
			assign sat_in  = smag;
		end else begin : g_next
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign q_in    = sq_q_s[k-1];
			assign sat_in  = sq_sat_s[k-1];
		end
		assign t     = {rem_in[RW-3:0], q_in[MQW-1:MQW-2]};
		assign trial = RW'({root_in, 2'b01});
		assign ge    = t >= trial;
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[k]  <= ge ? t - trial : t;
				sq_root_s[k] <= {root_in[MAG_W-2:0], ge};
				sq_q_s[k]    <= {q_in[MQW-3:0], 2'b00};
				sq_sat_s[k]  <= sat_in;
			end
		end
	end

	// Phase difference.
	logic signed [ANG_W-1:0] ang_ref, ang_cell;
	logic signed [ANG_W:0]   dang, dround, dsh;
	logic signed [PH_W-1:0]  ph_c, ph_s22;

	ric_cordic u_cordic_ref (
		.clk (clk), .en (adv), .x (item.ref_real), .y (item.ref_imag), .z (ang_ref)
	);

	ric_cordic u_cordic_cell (
		.clk (clk), .en (adv), .x (item.cell_real), .y (item.cell_imag), .z (ang_cell)
	);

	always_comb begin
		dang   = (ANG_W+1)'(ang_cell) - (ANG_W+1)'(ang_ref);
		dround = dang + (ANG_W+1)'(128);
		dsh    = dround >>> 8;
		if (dsh > ric_pkg::PHASE_LIM) begin
			ph_c = PH_W'(ric_pkg::PHASE_LIM);
		end else if (dsh < -ric_pkg::PHASE_LIM) begin
			ph_c = PH_W'(-ric_pkg::PHASE_LIM);
		end else begin
			ph_c = PH_W'(dsh);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s22 <= ph_c;
		end
	end

	// Sign bits wait for the part quotients; formatted parts and phase wait for the root.
	logic [1:0]               neg_dly_s [NEG_DLY];
	logic signed [PART_W-1:0] zr_s62, zi_s62, zr_c, zi_c;
	logic signed [PART_W-1:0] zr_dly_s [PART_DLY];
	logic signed [PART_W-1:0] zi_dly_s [PART_DLY];
	logic signed [PH_W-1:0]   ph_dly_s [PH_DLY];

	always_comb begin
		if (sre) begin
			zr_c = neg_dly_s[NEG_DLY-1][1] ? NEG_SAT : POS_SAT;
		end else begin
			zr_c = neg_dly_s[NEG_DLY-1][1] ? -$signed({1'b0, qre}) : $signed({1'b0, qre});
		end
		if (sim) begin
			zi_c = neg_dly_s[NEG_DLY-1][0] ? NEG_SAT : POS_SAT;
		end else begin
			zi_c = neg_dly_s[NEG_DLY-1][0] ? -$signed({1'b0, qim}) : $signed({1'b0, qim});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_dly_s[0] <= {pn_s2, qn_s2};
			for (int k = 1; k < NEG_DLY; k++) begin
				neg_dly_s[k] <= neg_dly_s[k-1];
			end
			zr_s62 <= zr_c;
			zi_s62 <= zi_c;
			zr_dly_s[0] <= zr_s62;
			zi_dly_s[0] <= zi_s62;
			for (int k = 1; k < PART_DLY; k++) begin
				zr_dly_s[k] <= zr_dly_s[k-1];
				zi_dly_s[k] <= zi_dly_s[k-1];
			end
			ph_dly_s[0] <= ph_s22;
			for (int k = 1; k < PH_DLY; k++) begin
				ph_dly_s[k] <= ph_dly_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.z_magnitude <= sq_sat_s[MAG_W-1] ? {MAG_W{1'b1}} : sq_root_s[MAG_W-1];
			result.z_phase     <= ph_dly_s[PH_DLY-1];
			result.z_real      <= zr_dly_s[PART_DLY-1];
			result.z_imag      <= zi_dly_s[PART_DLY-1];
		end
	end

	`RIC_ASSERT_IMP(a_phase_range, clk, arst_n, result.valid, (result.z_phase <= ric_pkg::PHASE_LIM) && (result.z_phase >= -ric_pkg::PHASE_LIM))
	`RIC_ASSERT_NXT(a_stall_freeze, clk, arst_n, !adv, $stable(v_s))
	`RIC_ASSERT_NXT(a_drain, clk, arst_n, adv && v_s[LAST-1], result.valid)

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the ratiometric impedance calculator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [ric_pkg::IN_W-1:0] ref_real;
		logic signed [ric_pkg::IN_W-1:0] ref_imag;
		logic signed [ric_pkg::IN_W-1:0] cell_real;
		logic signed [ric_pkg::IN_W-1:0] cell_imag;
	} dft_pair_t;

	typedef struct {
		logic [ric_pkg::MAG_W-1:0] z_magnitude;
		logic signed [ric_pkg::PH_W-1:0] z_phase;
		logic signed [ric_pkg::PART_W-1:0] z_real;
		logic signed [ric_pkg::PART_W-1:0] z_imag;
	} impedance_t;

	typedef struct {
		dft_pair_t pair;
		bit typed;
		impedance_t z;
	} directed_row_t;

	localparam longint ANGLE_UNIT = 65536;
	localparam longint ARCTAN [ric_pkg::CORDIC_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ric_pkg::R_W-1:0] cfg_wdata;

	ric_item_if items ();
	ric_result_if res ();

	ratiometric_impedance_calc_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(items),
		.result(res)
	);

	impedance_t expected_z[$];
	logic [ric_pkg::R_W-1:0] ohms_model;
	int send_idle;
	int recv_idle;
	int fail_count;
	int pair_count;
	int result_count;
	bit hold_req;
	bit hold_on;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint angle_of(input longint x, input longint y);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		if (y == 0) begin
			return (x < 0) ? 180 * ANGLE_UNIT : 0;
		end
		if (x == 0) begin
			return (y > 0) ? 90 * ANGLE_UNIT : -90 * ANGLE_UNIT;
		end
		if (x < 0) begin
			z = (y > 0) ? 180 * ANGLE_UNIT : -180 * ANGLE_UNIT;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < ric_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += ARCTAN[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ARCTAN[i];
			end
		end
		return z;
	endfunction

	function automatic logic signed [ric_pkg::PART_W-1:0] scaled_part(
			input logic signed [127:0] v,
			input logic [127:0] scale8, input logic [127:0] sc);
		logic [127:0] mag;
		logic [127:0] quo;
		bit neg;
		neg = v < 0;
		mag = neg ? -v : v;
		quo = (mag * scale8) / sc;
		if (quo >= (128'd1 << 56)) begin
			return neg ? -(57'sd1 <<< 56) : {1'b0, {56{1'b1}}};
		end
		return neg ? -quo[ric_pkg::PART_W-1:0] : quo[ric_pkg::PART_W-1:0];
	endfunction

	function automatic impedance_t predict_impedance(input dft_pair_t p);
		logic signed [127:0] rr, ri, cr, ci, pw, qw;
		logic [127:0] sr, sc, scale, quo, cand;
		logic [ric_pkg::MAG_W-1:0] root;
		longint d, ph;
		impedance_t z;
		rr = p.ref_real;
		ri = p.ref_imag;
		cr = p.cell_real;
		ci = p.cell_imag;
		sr = rr * rr + ri * ri;
		sc = cr * cr + ci * ci;
		if (sc == 0) begin
			sc = 1;
			pw = rr;
			qw = -ri;
		end else begin
			pw = rr * cr + ri * ci;
			qw = rr * ci - ri * cr;
		end
		scale = ohms_model;
		quo = (sr * ((scale * scale) << 16)) / sc;
		root = '0;
		if (quo >= (128'd1 << 112)) begin
			root = '1;
		end else begin
			for (int b = ric_pkg::MAG_W - 1; b >= 0; b--) begin
				cand = root | (56'd1 << b);
				if (cand * cand <= quo) root = cand[ric_pkg::MAG_W-1:0];
			end
		end
		d = angle_of(longint'(cr), longint'(ci)) - angle_of(longint'(rr), longint'(ri));
		ph = (d + 128) >>> 8;
		if (ph > ric_pkg::PHASE_LIM) ph = ric_pkg::PHASE_LIM;
		if (ph < -ric_pkg::PHASE_LIM) ph = -ric_pkg::PHASE_LIM;
		z.z_magnitude = root;
		z.z_phase = ph[ric_pkg::PH_W-1:0];
		z.z_real = scaled_part(pw, scale << 8, sc);
		z.z_imag = scaled_part(qw, scale << 8, sc);
		return z;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		impedance_t want;
		if (arst_n && res.valid && res.ready) begin
			result_count++;
			if (expected_z.size() == 0) begin
				report_mismatch("unexpected result", res.z_magnitude, 0);
			end else begin
				want = expected_z.pop_front();
				if (res.z_magnitude !== want.z_magnitude)
					report_mismatch("z_magnitude", res.z_magnitude, want.z_magnitude);
				if (res.z_phase !== want.z_phase)
					report_mismatch("z_phase", 64'(res.z_phase), 64'(want.z_phase));
				if (res.z_real !== want.z_real)
					report_mismatch("z_real", 64'(res.z_real), 64'(want.z_real));
				if (res.z_imag !== want.z_imag)
					report_mismatch("z_imag", 64'(res.z_imag), 64'(want.z_imag));
			end
		end
		res.ready <= hold_on ? 1'b0 : ($urandom_range(99) >= recv_idle);
	end

	initial begin
		hold_on = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
				hold_req = 1'b0;
			end
		end
	end

	task automatic send_pair(input dft_pair_t p, input bit typed, input impedance_t z);
		if ($urandom_range(99) < send_idle) begin
			items.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		items.valid <= 1'b1;
		items.ref_real <= p.ref_real;
		items.ref_imag <= p.ref_imag;
		items.cell_real <= p.cell_real;
		items.cell_imag <= p.cell_imag;
		do @(posedge clk); while (!items.ready);
		pair_count++;
		expected_z.push_back(typed ? z : predict_impedance(p));
	endtask

	task automatic drain();
		items.valid <= 1'b0;
		while (expected_z.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_ohms(input logic [ric_pkg::R_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ohms_model = v;
	endtask

	function automatic logic signed [ric_pkg::IN_W-1:0] pick_field();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(64)) - 32;
			2: begin
				case ($urandom_range(4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: return $signed($urandom) >>> $urandom_range(31);
		endcase
	endfunction

	function automatic dft_pair_t random_pair();
		dft_pair_t p;
		p.ref_real = pick_field();
		p.ref_imag = pick_field();
		p.cell_real = pick_field();
		p.cell_imag = pick_field();
		if ($urandom_range(19) == 0) begin
			p.cell_real = 0;
			p.cell_imag = 0;
		end
		return p;
	endfunction

	localparam int MAX_P = 32'sh7fffffff;
	localparam int MIN_N = 32'sh80000000;

	directed_row_t directed [20] = '{
		'{'{0, 0, 0, 0}, 1, '{0, 0, 0, 0}},
		'{'{1, 0, 1, 0}, 1, '{51200, 0, 51200, 0}},
		'{'{0, 1, 1, 0}, 1, '{51200, -23040, 0, -51200}},
		'{'{MAX_P, MAX_P, MAX_P, MAX_P}, 0, '{0, 0, 0, 0}},
		'{'{MIN_N, MIN_N, MIN_N, MIN_N}, 0, '{0, 0, 0, 0}},
		'{'{MIN_N, MIN_N, 0, 0}, 0, '{0, 0, 0, 0}},
		'{'{MAX_P, MIN_N, 1, 0}, 0, '{0, 0, 0, 0}},
		'{'{MIN_N, MAX_P, 0, 1}, 0, '{0, 0, 0, 0}},
		'{'{-1, 0, 1, 0}, 0, '{0, 0, 0, 0}},
		'{'{0, -1, 1, 0}, 0, '{0, 0, 0, 0}},
		'{'{1, 0, -5, 3}, 0, '{0, 0, 0, 0}},
		'{'{1, 0, -5, -3}, 0, '{0, 0, 0, 0}},
		'{'{-1, 0, -1, 0}, 0, '{0, 0, 0, 0}},
		'{'{-7, 0, 0, 0}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 123, -456}, 0, '{0, 0, 0, 0}},
		'{'{MAX_P, 0, 0, 1}, 0, '{0, 0, 0, 0}},
		'{'{1, 1, MAX_P, MAX_P}, 0, '{0, 0, 0, 0}},
		'{'{-3, 4, 3, 4}, 0, '{0, 0, 0, 0}},
		'{'{3, -4, -4, 3}, 0, '{0, 0, 0, 0}},
		'{'{MIN_N, 0, MAX_P, 0}, 0, '{0, 0, 0, 0}}
	};

	logic [ric_pkg::R_W-1:0] ohms_steps [6] = '{17'd1, 17'd100000, 17'd131071, 17'd0,
		17'd200, 17'd4711};

	initial begin
		impedance_t none;
		none = '{0, 0, 0, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		items.valid = 1'b0;
		items.ref_real = '0;
		items.ref_imag = '0;
		items.cell_real = '0;
		items.cell_imag = '0;
		res.ready = 1'b0;
		hold_req = 1'b0;
		fail_count = 0;
		pair_count = 0;
		result_count = 0;
		ohms_model = ric_pkg::R_RESET;
		send_idle = 15;
		recv_idle = 77;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_pair(directed[i].pair, directed[i].typed, directed[i].z);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin send_idle = 15; recv_idle = 77; end
				1: begin send_idle = 77; recv_idle = 15; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			if (ph == 5) ohms_steps[ph] = $urandom_range(131071);
			write_ohms(ohms_steps[ph]);
			for (int n = 0; n < 290; n++) begin
				if (ph == 2 && n == 50) hold_req = 1'b1;
				if (ph == 1 && n == 150) drain();
				send_pair(random_pair(), 0, none);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Sent %0d DFT pairs and checked %0d results over six resistor settings,",
			pair_count, result_count);
		$display("including 0 and full scale, with idle, stall and back-pressure mixes.");
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#3ms;
		$display("Timed out with %0d results outstanding.", expected_z.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
